### rtl/mkd_pkg.sv
package mkd_pkg;

  localparam int MaxSymbolsDef = 8;

  localparam logic [15:0] SatTicks = 16'hFFFF;

  localparam logic [15:0] DashThresholdRst = 16'd4;
  localparam logic [15:0] LetterGapRst     = 16'd10;
  localparam logic [15:0] WordGapRst       = 16'd30;

  localparam int RegIdxW = 2;

  typedef enum logic [RegIdxW-1:0] {
    REG_DASH_THRESHOLD = 2'd0,
    REG_LETTER_GAP     = 2'd1,
    REG_WORD_GAP       = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_LETTER = 2'd0,
    EV_SPACE  = 2'd1,
    EV_DOT    = 2'd2,
    EV_DASH   = 2'd3
  } event_t;

  localparam logic [6:0] AsciiSpace = 7'h20;
  localparam logic [6:0] AsciiA     = 7'h41;
  localparam logic [6:0] NoLetter   = 7'h00;

  typedef struct packed {
    logic [3:0] bits;
    logic [2:0] len;
  } morse_entry_t;

  localparam int NumLetters = 26;

  // entry k is letter A+k; bit j is symbol j, 1 = dash
  localparam morse_entry_t MorseTable [NumLetters] = '{
    '{4'd2, 3'd2},  '{4'd1, 3'd4},  '{4'd5, 3'd4},  '{4'd1, 3'd3},  '{4'd0, 3'd1},
    '{4'd4, 3'd4},  '{4'd3, 3'd3},  '{4'd0, 3'd4},  '{4'd0, 3'd2},  '{4'd14, 3'd4},
    '{4'd5, 3'd3},  '{4'd2, 3'd4},  '{4'd3, 3'd2},  '{4'd1, 3'd2},  '{4'd7, 3'd3},
    '{4'd6, 3'd4},  '{4'd11, 3'd4}, '{4'd2, 3'd3},  '{4'd0, 3'd3},  '{4'd1, 3'd1},
    '{4'd4, 3'd3},  '{4'd8, 3'd4},  '{4'd6, 3'd3},  '{4'd9, 3'd4},  '{4'd13, 3'd4},
    '{4'd3, 3'd4}
  };

  // return ASCII letter, or zero when nothing matches; len 0 never matches
  function automatic logic [6:0] letter_lookup(input logic [2:0] len, input logic [3:0] bits);
    logic [6:0] code;
    code = NoLetter;
    for (int k = NumLetters - 1; k >= 0; k--) begin
      if (len == MorseTable[k].len && bits == MorseTable[k].bits) begin
        code = AsciiA + 7'(k);
      end
    end
    return code;
  endfunction

endpackage

### rtl/morse_keyer_decoder_top.sv
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ---------------------
// sample    in         sample_valid / sample_ready  key_down, tick
// result    out        result_valid / result_ready  event_res, char_code
// config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// One sample per clock while sample_ready is high: each accepted sample is evaluated
// in a single pass of logic between the decoder state registers and the result
// register, so result_valid rises in the cycle after acceptance.
// A sample that causes no event produces no result transaction.
// sample_ready drops only while a result is held and result_ready is low.
// rst is synchronous, active high; it clears decoder state and restores the
// register defaults (dash 4, letter gap 10, word gap 30 ticks).
module morse_keyer_decoder_top
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MaxSymbolsDef
) (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic        key_down,
  input  logic        tick,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  event_res,
  output logic [6:0]  char_code,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // symbol count saturates at MAX_SYMBOLS+1
  localparam int CntW = $clog2(MAX_SYMBOLS + 2);
  localparam int IdxW = $clog2(MAX_SYMBOLS);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_SYMBOLS);
  localparam logic [CntW-1:0] CntOver = CntW'(MAX_SYMBOLS + 1);
  localparam logic [CntW-1:0] CntMaxLen = CntW'(4);

  // configuration registers
  logic [15:0] dash_threshold;
  logic [15:0] letter_gap;
  logic [15:0] word_gap;

  // decoder state
  logic                   previous_key, previous_key_next;
  logic [15:0]            press_ticks, press_ticks_next;
  logic [15:0]            quiet_ticks, quiet_ticks_next;
  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic [CntW-1:0]        symbol_count, symbol_count_next;
  logic                   space_pending, space_pending_next;

  // result register inputs
  logic       fire;
  logic [1:0] event_next;
  logic [6:0] code_next;

  logic        wr_en;
  logic [RegIdxW-1:0] reg_idx;
  logic        accept;
  logic [15:0] press_cur;
  logic [15:0] quiet_cur;
  logic        key_rise;
  logic        key_fall;
  logic        is_dash;
  logic [2:0]  match_len;
  logic [6:0]  letter;

  // APB: zero wait states, register index from the word address
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_threshold <= DashThresholdRst;
      letter_gap     <= LetterGapRst;
      word_gap       <= WordGapRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DASH_THRESHOLD: dash_threshold <= pwdata[15:0];
        REG_LETTER_GAP:     letter_gap     <= pwdata[15:0];
        REG_WORD_GAP:       word_gap       <= pwdata[15:0];
        default: ;  // write beyond the register list: drop it
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DASH_THRESHOLD: prdata = {16'd0, dash_threshold};
      REG_LETTER_GAP:     prdata = {16'd0, letter_gap};
      REG_WORD_GAP:       prdata = {16'd0, word_gap};
      default:            prdata = 32'd0;
    endcase
  end

  // accept a new sample whenever the result register is empty or draining
  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;

  // advance both tick counters before the sample is evaluated
  assign press_cur = (tick && press_ticks != SatTicks) ? press_ticks + 16'd1 : press_ticks;
  assign quiet_cur = (tick && quiet_ticks != SatTicks) ? quiet_ticks + 16'd1 : quiet_ticks;

  assign key_rise = key_down && !previous_key;
  assign key_fall = !key_down && previous_key;
  assign is_dash  = press_cur >= dash_threshold;

  // only counts of one to four can be table letters
  assign match_len = (symbol_count <= CntMaxLen) ? symbol_count[2:0] : 3'd0;
  assign letter    = letter_lookup(match_len, symbol_bits[3:0]);

  always_comb begin
    previous_key_next  = key_down;
    press_ticks_next   = press_cur;
    quiet_ticks_next   = quiet_cur;
    symbol_bits_next   = symbol_bits;
    symbol_count_next  = symbol_count;
    space_pending_next = space_pending;
    fire               = 1'b0;
    event_next         = EV_DOT;
    code_next          = NoLetter;

    if (key_rise) begin
      // restart press timing on the press edge
      press_ticks_next = 16'd0;
    end else if (key_fall) begin
      // classify the press, store the symbol if room is left, echo it
      quiet_ticks_next = 16'd0;
      if (symbol_count < CntMax) begin
        symbol_bits_next[symbol_count[IdxW-1:0]] = is_dash;
        symbol_count_next = symbol_count + CntW'(1);
      end else begin
        symbol_count_next = CntOver;
      end
      fire       = 1'b1;
      event_next = is_dash ? EV_DASH : EV_DOT;
    end else if (!key_down && symbol_count != '0 && quiet_cur >= letter_gap) begin
      // letter gap reached: emit the letter, or drop an unknown pattern
      if (letter != NoLetter) begin
        space_pending_next = 1'b1;
        fire               = 1'b1;
        event_next         = EV_LETTER;
        code_next          = letter;
      end
      symbol_count_next = '0;
      symbol_bits_next  = '0;
      quiet_ticks_next  = 16'd0;
    end else if (!key_down && symbol_count == '0 && space_pending &&
                 quiet_cur >= word_gap) begin
      // word gap after a letter: one space
      space_pending_next = 1'b0;
      quiet_ticks_next   = 16'd0;
      fire               = 1'b1;
      event_next         = EV_SPACE;
      code_next          = AsciiSpace;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key  <= 1'b0;
      press_ticks   <= 16'd0;
      quiet_ticks   <= 16'd0;
      symbol_bits   <= '0;
      symbol_count  <= '0;
      space_pending <= 1'b0;
    end else if (accept) begin
      previous_key  <= previous_key_next;
      press_ticks   <= press_ticks_next;
      quiet_ticks   <= quiet_ticks_next;
      symbol_bits   <= symbol_bits_next;
      symbol_count  <= symbol_count_next;
      space_pending <= space_pending_next;
    end
  end

  // result register: load on an accepted sample that fires, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= fire;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      event_res <= event_next;
      char_code <= code_next;
    end
  end

endmodule
